// ===== src/sme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_pkg
// Types and codes shared by the stack machine executor files.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam logic [3:0] OP_LD  = 4'd0;
    localparam logic [3:0] OP_ST  = 4'd1;
    localparam logic [3:0] OP_LDC = 4'd2;
    localparam logic [3:0] OP_ADD = 4'd3;
    localparam logic [3:0] OP_SUB = 4'd4;
    localparam logic [3:0] OP_CMP = 4'd5;
    localparam logic [3:0] OP_JMP = 4'd6;
    localparam logic [3:0] OP_BR  = 4'd7;
    localparam logic [3:0] OP_RET = 4'd8;

    localparam logic [2:0] ERR_OK     = 3'd0;
    localparam logic [2:0] ERR_OVER   = 3'd1;
    localparam logic [2:0] ERR_UNDER  = 3'd2;
    localparam logic [2:0] ERR_OPCODE = 3'd3;
    localparam logic [2:0] ERR_ADDR   = 3'd4;

    typedef struct packed {
        logic [3:0]         kind;
        logic [9:0]         mem_address;
        logic signed [31:0] constant;
        logic [7:0]         jump_target;
    } sme_in_t;

    typedef struct packed {
        logic [7:0]         next_ip;
        logic               halted;
        logic signed [31:0] return_value;
        logic [2:0]         error_code;
    } sme_out_t;

endpackage

// ===== src/sme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/stack_machine_executor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// Executes one decoded stack-machine instruction per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry decoded instructions, m_valid/m_ready/m_data
//   carry one result per instruction (next ip, halt flag, return value, error).
//   m_valid rises after an accepted request leaves the second stage. A new request
//   is taken every cycle: the first stage checks the stack count and issues
//   reads to the stack RAM and the data RAM, the second stage computes and
//   writes back. The two top stack entries live in registers, the rest of the
//   stack and the data memory live in single-read-port RAMs, with a bypass
//   for a read that meets a write to the same word in the same cycle.
//   Throughput is one instruction per cycle while m_ready stays high.
//   When the receiver stalls, the result is held in the output register, one
//   more request is taken into the second stage and s_ready then drops.
//   Reset (aresetn low, synchronous) empties the stack, zeroes the
//   instruction pointer and drops m_valid; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module stack_machine_executor_core
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH   = 1024,
    parameter int MEM_WORDS     = 1024,
    parameter int PROGRAM_SLOTS = 256
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sme_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sme_out_t m_data
);

    localparam int CW         = $clog2(STACK_DEPTH + 1);
    localparam int SAW        = $clog2(STACK_DEPTH);
    localparam int DMEM_DEPTH = (MEM_WORDS < 1024) ? MEM_WORDS : 1024;
    localparam int DAW        = $clog2(DMEM_DEPTH);

    // first stage
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           s_accept;
    logic           addr_bad, tgt_bad;
    logic           cnt_empty, cnt_full, cnt_lt2;
    logic [2:0]     dec_err;
    logic           dec_push, dec_pop;
    logic [CW-1:0]  cnt_m3;
    logic [SAW-1:0] srd_addr;
    logic [DAW-1:0] drd_addr;

    // second stage
    logic           p_valid_reg;
    logic [3:0]     p_kind_reg;
    logic [2:0]     p_err_reg;
    logic           p_push_reg, p_pop_reg;
    logic [CW-1:0]  p_cnt_reg;
    logic [9:0]     p_addr_reg;
    logic [31:0]    p_const_reg;
    logic [7:0]     p_target_reg;
    logic           p_tgt_bad_reg;
    logic           sbyp_reg, dbyp_reg;
    logic [31:0]    sbyp_data_reg, dbyp_data_reg;
    logic           fire2;

    logic [31:0]    tos_reg, tos_next;
    logic [31:0]    nos_reg, nos_next;
    logic [7:0]     ip_reg, ip_next;

    logic [31:0]    st_rdata, dm_rdata, srd, drd;
    logic           st_we, dm_we;
    logic [CW-1:0]  p_cnt_m2;
    logic [SAW-1:0] st_waddr;
    logic [DAW-1:0] dm_waddr;

    logic [8:0]     ip_inc;
    logic [7:0]     seq_ip;
    logic [31:0]    push_val;
    logic           br_taken;
    sme_out_t       res;

    logic           m_valid_reg;
    sme_out_t       m_data_reg;

    assign fire2    = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p_valid_reg || fire2;
    assign s_accept = s_valid && s_ready;

    // request checks against the stack count, the data address and the jump target
    assign addr_bad  = 32'(s_data.mem_address) >= 32'(MEM_WORDS);
    assign tgt_bad   = 32'(s_data.jump_target) >= 32'(PROGRAM_SLOTS);
    assign cnt_empty = cnt_reg == '0;
    assign cnt_full  = cnt_reg == CW'(STACK_DEPTH);
    assign cnt_lt2   = cnt_reg < CW'(2);

    always_comb begin
        dec_err  = ERR_OK;
        dec_push = 1'b0;
        dec_pop  = 1'b0;
        case (s_data.kind)
            OP_LD: begin
                if (addr_bad)       dec_err = ERR_ADDR;
                else if (cnt_full)  dec_err = ERR_OVER;
                else                dec_push = 1'b1;
            end
            OP_ST: begin
                if (addr_bad)       dec_err = ERR_ADDR;
                else if (cnt_empty) dec_err = ERR_UNDER;
                else                dec_pop = 1'b1;
            end
            OP_LDC: begin
                if (cnt_full)       dec_err = ERR_OVER;
                else                dec_push = 1'b1;
            end
            OP_ADD, OP_SUB, OP_CMP: begin
                if (cnt_lt2)        dec_err = ERR_UNDER;
                else if (cnt_full)  dec_err = ERR_OVER;
                else                dec_push = 1'b1;
            end
            OP_JMP: begin
                if (tgt_bad)        dec_err = ERR_ADDR;
            end
            OP_BR, OP_RET: begin
                if (cnt_empty)      dec_err = ERR_UNDER;
            end
            default: begin
                dec_err = ERR_OPCODE;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (dec_push)     cnt_next = cnt_reg + CW'(1);
        else if (dec_pop) cnt_next = cnt_reg - CW'(1);
    end

    // entry that becomes second after a pop
    assign cnt_m3   = cnt_reg - CW'(3);
    assign srd_addr = cnt_m3[SAW-1:0];
    assign drd_addr = s_data.mem_address[DAW-1:0];

    // write-back from the second stage
    assign p_cnt_m2 = p_cnt_reg - CW'(2);
    assign st_waddr = p_cnt_m2[SAW-1:0];
    assign st_we    = fire2 && p_push_reg && (p_cnt_reg >= CW'(2));
    assign dm_waddr = p_addr_reg[DAW-1:0];
    assign dm_we    = fire2 && p_pop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                cnt_reg <= cnt_next;
            end
            if (s_ready) begin
                p_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_kind_reg    <= s_data.kind;
            p_err_reg     <= dec_err;
            p_push_reg    <= dec_push;
            p_pop_reg     <= dec_pop;
            p_cnt_reg     <= cnt_reg;
            p_addr_reg    <= s_data.mem_address;
            p_const_reg   <= s_data.constant;
            p_target_reg  <= s_data.jump_target;
            p_tgt_bad_reg <= tgt_bad;
            sbyp_reg      <= st_we && (st_waddr == srd_addr);
            sbyp_data_reg <= nos_reg;
            dbyp_reg      <= dm_we && (dm_waddr == drd_addr);
            dbyp_data_reg <= tos_reg;
        end
    end

    sme_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (nos_reg),
        .rd_en   (s_accept),
        .rd_addr (srd_addr),
        .rd_data (st_rdata)
    );

    sme_ram #(
        .WIDTH (32),
        .DEPTH (DMEM_DEPTH)
    ) u_data_ram (
        .clk     (aclk),
        .wr_en   (dm_we),
        .wr_addr (dm_waddr),
        .wr_data (tos_reg),
        .rd_en   (s_accept),
        .rd_addr (drd_addr),
        .rd_data (dm_rdata)
    );

    assign srd = sbyp_reg ? sbyp_data_reg : st_rdata;
    assign drd = dbyp_reg ? dbyp_data_reg : dm_rdata;

    assign ip_inc = {1'b0, ip_reg} + 9'd1;
    assign seq_ip = (32'(ip_inc) >= 32'(PROGRAM_SLOTS)) ? 8'd0 : ip_inc[7:0];

    always_comb begin
        case (p_kind_reg)
            OP_LD:   push_val = drd;
            OP_ADD:  push_val = tos_reg + nos_reg;
            OP_SUB:  push_val = tos_reg - nos_reg;
            OP_CMP: begin
                if ($signed(tos_reg) > $signed(nos_reg))      push_val = 32'd1;
                else if ($signed(tos_reg) < $signed(nos_reg)) push_val = '1;
                else                                          push_val = '0;
            end
            default: push_val = p_const_reg;
        endcase
    end

    assign br_taken = tos_reg != '0;

    always_comb begin
        tos_next         = tos_reg;
        nos_next         = nos_reg;
        res.next_ip      = seq_ip;
        res.halted       = 1'b0;
        res.return_value = '0;
        res.error_code   = p_err_reg;
        if (p_push_reg) begin
            tos_next = push_val;
            nos_next = tos_reg;
        end else if (p_pop_reg) begin
            tos_next = nos_reg;
            nos_next = srd;
        end else if (p_err_reg == ERR_OK) begin
            case (p_kind_reg)
                OP_JMP: begin
                    res.next_ip = p_target_reg;
                end
                OP_BR: begin
                    if (br_taken) begin
                        if (p_tgt_bad_reg) res.error_code = ERR_ADDR;
                        else               res.next_ip    = p_target_reg;
                    end
                end
                OP_RET: begin
                    res.halted       = 1'b1;
                    res.return_value = tos_reg;
                    res.next_ip      = ip_reg;
                end
                default: begin
                    res.next_ip = seq_ip;
                end
            endcase
        end
        ip_next = res.next_ip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire2) begin
                ip_reg      <= ip_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire2) begin
            tos_reg    <= tos_next;
            nos_reg    <= nos_next;
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/sme_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_checker
// Port-level checks for the stack machine executor, bound to the top level.
// ----------------------------------------------------------------------------
module sme_checker
    import sme_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input sme_out_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // input side only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request refused without output stall");

    // a halt carries no error
    a_halt_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.halted |-> m_data.error_code == ERR_OK)
        else $error("halt reported with error");

    // errors give no halt and a zero return value
    a_err_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != ERR_OK |->
            !m_data.halted && m_data.return_value == '0)
        else $error("error result carries halt or value");

    // reset drops the result channel
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind stack_machine_executor_core sme_checker u_sme_checker (.*);
